// File: rtl/core/utf8v_pkg.sv
package utf8v_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned LEN_W   = 16;

    localparam logic CFG_ALLOW_EMPTY = 1'b0;
    localparam logic CFG_MAX_LENGTH  = 1'b1;

    localparam logic             ALLOW_EMPTY_RST = 1'b1;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST  = 16'd4096;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_2B  = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3B  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4B  = 21'h010000;

    localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;
    localparam logic [BYTE_W-1:0] TAIL_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] TAIL_VAL   = 8'h80;
    localparam logic [BYTE_W-1:0] TAIL_BITS  = 8'h3F;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              no_byte;
        logic              end_of_string;
    } item_t;

    typedef struct packed {
        logic             allow_empty;
        logic [LEN_W-1:0] max_length;
    } cfg_t;

endpackage

// File: rtl/core/utf8_string_validator.sv
// UTF-8 string validator.
// Input stream s_axis: one byte of the string per word in tdata; tuser set
// marks a word that carries no byte (an empty string is a single such word
// with tlast set); tlast marks the final word of the string.
// Output stream m_axis: one word per string, produced for the word carrying
// tlast; tdata bit 0 is 1 when the string is strict UTF-8, holds no zero byte,
// has no cut-off sequence, is no longer than max_length bytes and is not
// empty unless allow_empty is 1. Config channel: cfg_index 0 writes
// allow_empty (cfg_data bit 0), index 1 writes max_length (cfg_data); write
// only while no string is in flight. Throughput: one word per cycle while
// s_axis_tready is high, set by one pass through the decoder between the
// input register and the result register. Reset clears the decoder, the
// pipeline and restores allow_empty = 1, max_length = 4096. When m_axis
// stalls the verdict holds in its register; words without tlast keep
// flowing until a second verdict is ready, then s_axis_tready drops until
// the output drains.
module utf8_string_validator
    import utf8v_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic                 s_axis_tuser,   // [0] no_byte
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [0] string_ok, [7:1] zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    cfg_t  cfg_reg;
    item_t in_item_reg;
    logic  in_valid_reg;
    logic  out_valid_reg;
    logic  out_ok_reg;

    logic  out_free;
    logic  consume;
    logic  string_ok;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign consume       = in_valid_reg && (!in_item_reg.end_of_string || out_free);
    assign s_axis_tready = !in_valid_reg || consume;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.allow_empty <= ALLOW_EMPTY_RST;
            cfg_reg.max_length  <= MAX_LENGTH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ALLOW_EMPTY: cfg_reg.allow_empty <= cfg_data[0];
                CFG_MAX_LENGTH:  cfg_reg.max_length  <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.data_byte     <= s_axis_tdata;
            in_item_reg.no_byte       <= s_axis_tuser;
            in_item_reg.end_of_string <= s_axis_tlast;
        end
    end

    utf8v_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (consume),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .string_ok (string_ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= consume && in_item_reg.end_of_string;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && consume && in_item_reg.end_of_string)
            out_ok_reg <= string_ok;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_ok_reg};

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stage empty but not ready");

    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(consume && in_item_reg.end_of_string))
        else $error("verdict without a final word");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !consume |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled word lost from input stage");
`endif

endmodule

// File: rtl/core/utf8v_check.sv
module utf8v_check
    import utf8v_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  item_t item,
    input  cfg_t  cfg,
    output logic  string_ok
);

    logic [1:0]         tails_left_reg, tails_left_next;
    logic [1:0]         seq_length_reg, seq_length_next;
    logic [CP_W-1:0]    code_point_acc_reg, code_point_acc_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic               error_seen_reg, error_seen_next;

    logic [BYTE_W-1:0]  b;
    logic [CP_W-1:0]    cp_shift;
    logic [CP_W-1:0]    cp_min;

    assign b        = item.data_byte;
    assign cp_shift = {code_point_acc_reg[CP_W-7:0], b[5:0] & TAIL_BITS[5:0]};

    always_comb
    begin
        case (seq_length_reg)
            2'd1:    cp_min = MIN_2B;
            2'd2:    cp_min = MIN_3B;
            default: cp_min = MIN_4B;
        endcase
    end

    always_comb
    begin
        tails_left_next     = tails_left_reg;
        seq_length_next     = seq_length_reg;
        code_point_acc_next = code_point_acc_reg;
        byte_count_next     = byte_count_reg;
        error_seen_next     = error_seen_reg;
        string_ok           = 1'b0;

        if (step && !item.no_byte)
        begin
            if (byte_count_reg != COUNT_MAX)
                byte_count_next = byte_count_reg + 17'd1;
            if (b == '0)
                error_seen_next = 1'b1;

            if (tails_left_reg == 2'd0)
            begin
                if (b <= ASCII_MAX)
                begin
                end
                else if ((b & LEAD2_MASK) == LEAD2_VAL)
                begin
                    seq_length_next     = 2'd1;
                    tails_left_next     = 2'd1;
                    code_point_acc_next = {16'd0, b[4:0]};
                end
                else if ((b & LEAD3_MASK) == LEAD3_VAL)
                begin
                    seq_length_next     = 2'd2;
                    tails_left_next     = 2'd2;
                    code_point_acc_next = {17'd0, b[3:0]};
                end
                else if ((b & LEAD4_MASK) == LEAD4_VAL)
                begin
                    seq_length_next     = 2'd3;
                    tails_left_next     = 2'd3;
                    code_point_acc_next = {18'd0, b[2:0]};
                end
                else
                begin
                    error_seen_next = 1'b1;
                end
            end
            else if ((b & TAIL_MASK) != TAIL_VAL)
            begin
                error_seen_next = 1'b1;
                tails_left_next = 2'd0;
            end
            else
            begin
                code_point_acc_next = cp_shift;
                tails_left_next     = tails_left_reg - 2'd1;
                if (tails_left_reg == 2'd1)
                begin
                    if (cp_shift < cp_min || cp_shift > CP_MAX
                        || (cp_shift inside {[SURR_LO:SURR_HI]}))
                        error_seen_next = 1'b1;
                end
            end
        end

        if (step && item.end_of_string)
        begin
            string_ok = !error_seen_next && tails_left_next == 2'd0
                        && byte_count_next <= {1'b0, cfg.max_length}
                        && !(byte_count_next == '0 && !cfg.allow_empty);
            tails_left_next     = 2'd0;
            seq_length_next     = 2'd0;
            code_point_acc_next = '0;
            byte_count_next     = '0;
            error_seen_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tails_left_reg     <= 2'd0;
            seq_length_reg     <= 2'd0;
            code_point_acc_reg <= '0;
            byte_count_reg     <= '0;
            error_seen_reg     <= 1'b0;
        end
        else
        begin
            tails_left_reg     <= tails_left_next;
            seq_length_reg     <= seq_length_next;
            code_point_acc_reg <= code_point_acc_next;
            byte_count_reg     <= byte_count_next;
            error_seen_reg     <= error_seen_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.end_of_string |=> byte_count_reg == '0 && tails_left_reg == 2'd0
            && !error_seen_reg)
        else $error("string state not cleared after verdict");

    a_tails_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        tails_left_reg <= seq_length_reg)
        else $error("more continuation bytes owed than sequence holds");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg == '0 |-> tails_left_reg == 2'd0 && !error_seen_reg)
        else $error("decode state set with no byte seen");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(byte_count_reg) && $stable(tails_left_reg))
        else $error("state moved without an item");
`endif

endmodule

// File: bench/tb_utf8_string_validator.sv
`timescale 1ns / 1ps

module tb_utf8_string_validator;
    import utf8v_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = CFG_ALLOW_EMPTY;
    logic [LEN_W-1:0]  cfg_data = '0;

    // decoder shadow
    logic [1:0]         tails_owed = '0;
    logic [1:0]         seq_tails = '0;
    logic [CP_W-1:0]    cp_acc = '0;
    logic [COUNT_W-1:0] str_count = '0;
    logic               str_bad = 1'b0;
    logic               allow_empty_cfg = ALLOW_EMPTY_RST;
    logic [LEN_W-1:0]   max_len_cfg = MAX_LENGTH_RST;

    logic              verdict_q[$];
    logic [BYTE_W-1:0] str_buf[$];

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int ignore_pct = 0;
    int words_sent = 0;
    int strings_done = 0;
    int ok_count = 0;
    int reject_count = 0;
    int fail_count = 0;
    int cycle_count = 0;

    utf8_string_validator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
                     verdict_q.size());
            $display("tb_utf8_string_validator: FAIL");
            $finish;
        end
    end

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        logic [CP_W-1:0] floor_cp;
        if (str_count != COUNT_MAX)
            str_count = str_count + 1'b1;
        if (b == 8'h00)
            str_bad = 1'b1;
        if (tails_owed == 2'd0)
        begin
            if ((b & LEAD2_MASK) == LEAD2_VAL)
            begin
                seq_tails = 2'd1;
                cp_acc = CP_W'(b[4:0]);
                tails_owed = 2'd1;
            end
            else if ((b & LEAD3_MASK) == LEAD3_VAL)
            begin
                seq_tails = 2'd2;
                cp_acc = CP_W'(b[3:0]);
                tails_owed = 2'd2;
            end
            else if ((b & LEAD4_MASK) == LEAD4_VAL)
            begin
                seq_tails = 2'd3;
                cp_acc = CP_W'(b[2:0]);
                tails_owed = 2'd3;
            end
            else if (b > ASCII_MAX)
                str_bad = 1'b1;
        end
        else if ((b & TAIL_MASK) != TAIL_VAL)
        begin
            str_bad = 1'b1;
            tails_owed = 2'd0;
        end
        else
        begin
            cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
            tails_owed = tails_owed - 2'd1;
            if (tails_owed == 2'd0)
            begin
                floor_cp = (seq_tails == 2'd1) ? MIN_2B : (seq_tails == 2'd2) ? MIN_3B : MIN_4B;
                if (cp_acc < floor_cp || cp_acc > CP_MAX ||
                    (cp_acc >= SURR_LO && cp_acc <= SURR_HI))
                    str_bad = 1'b1;
            end
        end
    endfunction

    function automatic void predict_word(input logic [BYTE_W-1:0] data, input logic nob,
                                         input logic last);
        logic ok;
        if (!nob)
            decode_byte(data);
        if (last)
        begin
            ok = !str_bad && tails_owed == 2'd0 && str_count <= {1'b0, max_len_cfg};
            if (str_count == '0 && !allow_empty_cfg)
                ok = 1'b0;
            verdict_q.push_back(ok);
            strings_done++;
            tails_owed = '0;
            seq_tails = '0;
            cp_acc = '0;
            str_count = '0;
            str_bad = 1'b0;
        end
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic void check_verdict();
        logic want;
        if (verdict_q.size() == 0)
            note_failure($sformatf("word %h with no verdict pending", m_axis_tdata));
        else
        begin
            want = verdict_q.pop_front();
            if (m_axis_tdata !== {7'b0, want})
                note_failure($sformatf("string_ok expected %b, got word %h", want,
                                       m_axis_tdata));
            else if (want)
                ok_count++;
            else
                reject_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_verdict();
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    task automatic send_word(input logic [BYTE_W-1:0] data, input logic nob, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= nob;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (!nob || last)
            words_sent++;
        predict_word(data, nob, last);
    endtask

    // drop valid and hold until every verdict is back and the pipeline is empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [LEN_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_ALLOW_EMPTY)
            allow_empty_cfg = value[0];
        else
            max_len_cfg = value;
    endtask

    task automatic send_buffered(input bit split_end);
        int n;
        n = str_buf.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < ignore_pct)
                send_word(8'($urandom_range(255)), 1'b1, 1'b0);
            send_word(str_buf[i], 1'b0, (i == n - 1) && !split_end);
        end
        if (split_end || n == 0)
            send_word(8'($urandom_range(255)), 1'b1, 1'b1);
    endtask

    function automatic void put_cp(input logic [CP_W-1:0] cp, input int n);
        case (n)
            1: str_buf.push_back({1'b0, cp[6:0]});
            2:
            begin
                str_buf.push_back({3'b110, cp[10:6]});
                str_buf.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                str_buf.push_back({4'b1110, cp[15:12]});
                str_buf.push_back({2'b10, cp[11:6]});
                str_buf.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                str_buf.push_back({5'b11110, cp[20:18]});
                str_buf.push_back({2'b10, cp[17:12]});
                str_buf.push_back({2'b10, cp[11:6]});
                str_buf.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void add_char();
        int kind;
        int k;
        kind = $urandom_range(99);
        k = $urandom_range(2, 4);
        if (kind < 40)
            str_buf.push_back(8'($urandom_range(1, 127)));
        else if (kind < 55)
            put_cp(CP_W'($urandom_range('h80, 'h7FF)), 2);
        else if (kind < 68)
            put_cp($urandom_range(1) ? CP_W'($urandom_range('h800, 'hD7FF))
                                     : CP_W'($urandom_range('hE000, 'hFFFF)), 3);
        else if (kind < 78)
            put_cp(CP_W'($urandom_range('h10000, 'h10FFFF)), 4);
        else if (kind < 82)
            put_cp(CP_W'($urandom_range(0, (k == 2) ? 'h7F : (k == 3) ? 'h7FF : 'hFFFF)), k);
        else if (kind < 85)
            put_cp(CP_W'($urandom_range('hD800, 'hDFFF)), 3);
        else if (kind < 88)
            put_cp(CP_W'($urandom_range('h110000, 'h1FFFFF)), 4);
        else if (kind < 91)
            str_buf.push_back(8'h00);
        else if (kind < 96)
            str_buf.push_back(8'($urandom_range(255)));
        else
        begin
            put_cp(CP_W'($urandom_range('h10000, 'h10FFFF)), k);
            repeat ($urandom_range(1, k - 1))
                void'(str_buf.pop_back());
        end
    endfunction

    function automatic void build_string();
        int n_chars;
        str_buf.delete();
        n_chars = ($urandom_range(99) < 6) ? 0 : $urandom_range(1, 6);
        repeat (n_chars)
            add_char();
    endfunction

    task automatic set_random_limits();
        write_reg(CFG_ALLOW_EMPTY, LEN_W'($urandom_range(1)));
        case ($urandom_range(4))
            0: write_reg(CFG_MAX_LENGTH, '0);
            1: write_reg(CFG_MAX_LENGTH, LEN_W'($urandom_range(1, 24)));
            2: write_reg(CFG_MAX_LENGTH, MAX_LENGTH_RST);
            3: write_reg(CFG_MAX_LENGTH, 16'hFFFF);
            default: write_reg(CFG_MAX_LENGTH, LEN_W'($urandom_range(16'hFFFF)));
        endcase
    endtask

    task automatic test_directed_cases();
        str_buf = '{8'h41};
        send_buffered(1'b0);
        str_buf.delete();
        send_buffered(1'b0);
        str_buf = '{8'hC2, 8'h80};
        send_buffered(1'b1);
        str_buf = '{8'hC1, 8'hBF};
        send_buffered(1'b0);
        str_buf = '{8'hED, 8'hA0, 8'h80};
        send_buffered(1'b0);
        str_buf = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_buffered(1'b0);
        str_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_buffered(1'b0);
        str_buf = '{8'h00};
        send_buffered(1'b0);
        str_buf = '{8'hE2, 8'h82};
        send_buffered(1'b0);
        str_buf = '{8'hC3, 8'h41};
        send_buffered(1'b0);
        str_buf = '{8'hFF};
        send_buffered(1'b0);
        // ignored word in the middle of a string
        send_word(8'h7F, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_length_and_empty();
        write_reg(CFG_ALLOW_EMPTY, '0);
        str_buf.delete();
        send_buffered(1'b0);
        str_buf = '{8'h41};
        send_buffered(1'b0);
        write_reg(CFG_MAX_LENGTH, '0);
        send_buffered(1'b0);
        str_buf.delete();
        send_buffered(1'b0);
        write_reg(CFG_ALLOW_EMPTY, 16'd1);
        send_buffered(1'b0);
        write_reg(CFG_MAX_LENGTH, 16'd3);
        str_buf = '{8'h61, 8'h62, 8'h63};
        send_buffered(1'b0);
        str_buf = '{8'h61, 8'h62, 8'h63, 8'h64};
        send_buffered(1'b1);
        str_buf = '{8'hE2, 8'h82, 8'hAC};
        send_buffered(1'b0);
        str_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80};
        send_buffered(1'b0);
        write_reg(CFG_MAX_LENGTH, MAX_LENGTH_RST);
    endtask

    task automatic test_random_strings(input int count);
        int stop_at;
        stop_at = words_sent + count;
        ignore_pct = 5;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(99) < 8)
                set_random_limits();
            else if ($urandom_range(99) < 3)
                wait_idle();
            build_string();
            send_buffered($urandom_range(99) < 30);
        end
        ignore_pct = 0;
    endtask

    task automatic send_ascii_run(input int len);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom_range('h20, 'h7E)), 1'b0, i == len - 1);
    endtask

    // longer strings right at and just past the length limit, then one with limit 65535
    task automatic test_long_strings();
        write_reg(CFG_ALLOW_EMPTY, 16'd1);
        write_reg(CFG_MAX_LENGTH, 16'd24);
        send_ascii_run(24);
        send_ascii_run(25);
        write_reg(CFG_MAX_LENGTH, 16'hFFFF);
        send_ascii_run(40);
        write_reg(CFG_MAX_LENGTH, MAX_LENGTH_RST);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 7;
        dst_idle_pct = 70;
        test_directed_cases();
        test_length_and_empty();
        test_random_strings(300);

        src_idle_pct = 70;
        dst_idle_pct = 7;
        test_random_strings(200);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_random_strings(80);
        test_long_strings();

        wait_idle();
        repeat (8) @(posedge clk);

        $display("checked %0d strings (%0d valid, %0d rejected), %0d words, %0d mismatches",
                 strings_done, ok_count, reject_count, words_sent, fail_count);
        $display("incl. empty strings, length limits 0..65535, runs at the limit, idle mixes");
        if (fail_count == 0)
            $display("tb_utf8_string_validator: PASS");
        else
            $display("tb_utf8_string_validator: FAIL");
        $finish;
    end

endmodule
